>>> rtl/lmcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcr_pkg
// Shared types and constants of the LED matrix circle rasterizer.
// ----------------------------------------------------------------------------
package lmcr_pkg;

   localparam int DEF_MAX_RADIUS = 63;
   localparam int DEF_MAX_SIDE   = 64;
   localparam int DEF_COORD_BITS = 10;
   localparam int STEP_LIMIT     = 46;
   localparam int NUM_PTS        = 8;

   localparam int SIDE_W   = 7;
   localparam int INDEX_W  = 13;
   localparam int RADIUS_W = 6;
   localparam int COLOR_W  = 24;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATRIX_WIDTH  = 3'd0,
      REG_MATRIX_HEIGHT = 3'd1,
      REG_HIDDEN_INDEX  = 3'd2,
      REG_SWAP_AXES     = 3'd3,
      REG_SERPENTINE    = 3'd4,
      REG_MIRROR_WIDTH  = 3'd5,
      REG_FLIP_HEIGHT   = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  width;
      logic [SIDE_W-1:0]  height;
      logic [INDEX_W-1:0] hidden;
      logic               swap;
      logic               serp;
      logic               mirror;
      logic               flip;
   } cfg_type;

endpackage

>>> rtl/lmcr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcr channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface lmcr_req_if #(parameter int COORD_BITS = 10);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic [5:0]                   radius;
   logic [23:0]                  color;
   modport source (output valid, center_x, center_y, radius, color, input ready);
   modport sink (input valid, center_x, center_y, radius, color, output ready);
endinterface

interface lmcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] pixel_index_0;
   logic [12:0] pixel_index_1;
   logic [12:0] pixel_index_2;
   logic [12:0] pixel_index_3;
   logic [12:0] pixel_index_4;
   logic [12:0] pixel_index_5;
   logic [12:0] pixel_index_6;
   logic [12:0] pixel_index_7;
   logic [23:0] pixel_color;
   logic        last_step;
   modport source (output valid, pixel_index_0, pixel_index_1, pixel_index_2,
      pixel_index_3, pixel_index_4, pixel_index_5, pixel_index_6, pixel_index_7,
      pixel_color, last_step, input ready);
   modport sink (input valid, pixel_index_0, pixel_index_1, pixel_index_2,
      pixel_index_3, pixel_index_4, pixel_index_5, pixel_index_6, pixel_index_7,
      pixel_color, last_step, output ready);
endinterface

interface lmcr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lmcr_map_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcr_map_pipe
// Three-stage pipeline that maps the eight octant points of one step to
// strip indices: bounds and mirroring, then the column multiply, then the
// final index with serpentine order and the hidden index.
// ----------------------------------------------------------------------------
module lmcr_map_pipe #(
   parameter int COORD_BITS = lmcr_pkg::DEF_COORD_BITS,
   parameter int MAX_SIDE   = lmcr_pkg::DEF_MAX_SIDE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lmcr_pkg::cfg_type                      cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [COORD_BITS:0]             in_px [8],
   input  logic signed [COORD_BITS:0]             in_py [8],
   input  logic [lmcr_pkg::COLOR_W-1:0]           in_color,
   input  logic                                   in_last,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [lmcr_pkg::INDEX_W-1:0]           out_idx [8],
   output logic [lmcr_pkg::COLOR_W-1:0]           out_color,
   output logic                                   out_last
);
   import lmcr_pkg::*;

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int CW = COORD_BITS + 1;
   localparam int PW = 2 * SW;

   logic [SW-1:0] w_eff, h_eff, len_eff;
   logic          adv1, adv2, adv3;

   logic [2:0]          v_ff, v_in;
   logic                s1_out_ff [8];
   logic [SW-1:0]       s1_x_ff [8], s1_y_ff [8];
   logic [COLOR_W-1:0]  s1_col_ff, s2_col_ff;
   logic                s1_last_ff, s2_last_ff;
   logic                s2_out_ff [8];
   logic [PW-1:0]       s2_base_ff [8];
   logic [SW-1:0]       s2_y_ff [8];
   logic                s2_odd_ff [8];
   logic [INDEX_W-1:0]  s3_idx_ff [8];
   logic [COLOR_W-1:0]  s3_col_ff;
   logic                s3_last_ff;

   assign w_eff = (int'(cfg.width) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(cfg.width);
   assign h_eff = (int'(cfg.height) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(cfg.height);
   assign len_eff = cfg.swap ? w_eff : h_eff;

   assign adv3 = !v_ff[2] || out_ready;
   assign adv2 = !v_ff[1] || adv3;
   assign adv1 = !v_ff[0] || adv2;
   assign in_ready = adv1;

   always_comb begin
      v_in = v_ff;
      if (adv1) begin
         v_in[0] = in_valid;
      end
      if (adv2) begin
         v_in[1] = v_ff[0];
      end
      if (adv3) begin
         v_in[2] = v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_col_ff  <= in_color;
         s1_last_ff <= in_last;
         for (int i = 0; i < 8; i++) begin
            logic [SW-1:0] xs, ys, xm, ym;
            xs = in_px[i][SW-1:0];
            ys = in_py[i][SW-1:0];
            xm = cfg.mirror ? SW'(w_eff - SW'(1) - xs) : xs;
            ym = cfg.flip ? SW'(h_eff - SW'(1) - ys) : ys;
            s1_out_ff[i] <= in_px[i] < 0 || in_py[i] < 0
               || in_px[i] >= $signed({{(CW-SW){1'b0}}, w_eff})
               || in_py[i] >= $signed({{(CW-SW){1'b0}}, h_eff});
            s1_x_ff[i] <= cfg.swap ? ym : xm;
            s1_y_ff[i] <= cfg.swap ? xm : ym;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
         for (int i = 0; i < 8; i++) begin
            s2_out_ff[i]  <= s1_out_ff[i];
            s2_base_ff[i] <= PW'(s1_x_ff[i]) * PW'(len_eff);
            s2_y_ff[i]    <= s1_y_ff[i];
            s2_odd_ff[i]  <= cfg.serp && s1_x_ff[i][0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_col_ff  <= s2_col_ff;
         s3_last_ff <= s2_last_ff;
         for (int i = 0; i < 8; i++) begin
            logic [PW-1:0] sum;
            sum = s2_odd_ff[i]
               ? PW'(s2_base_ff[i] + PW'(len_eff) - PW'(1) - PW'(s2_y_ff[i]))
               : PW'(s2_base_ff[i] + PW'(s2_y_ff[i]));
            s3_idx_ff[i] <= s2_out_ff[i] ? cfg.hidden : INDEX_W'(sum);
         end
      end
   end

   assign out_valid = v_ff[2];
   assign out_idx   = s3_idx_ff;
   assign out_color = s3_col_ff;
   assign out_last  = s3_last_ff;

endmodule

>>> rtl/led_matrix_circle_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_circle_rasterizer
// Midpoint circle rasterizer that maps each octant point to an LED index.
// ----------------------------------------------------------------------------
// One request item yields one result item per midpoint step, at one step a
// cycle when not stalled, about radius/sqrt(2)+1 items and at most 46; radius
// zero yields one. The step generator holds one circle at a time, so a request
// is taken once the previous circle's last step enters the mapping pipeline.
// Registers are to be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module led_matrix_circle_rasterizer #(
   parameter int MAX_RADIUS = lmcr_pkg::DEF_MAX_RADIUS,
   parameter int MAX_SIDE   = lmcr_pkg::DEF_MAX_SIDE,
   parameter int COORD_BITS = lmcr_pkg::DEF_COORD_BITS
) (
   input logic       clock,
   input logic       reset,
   lmcr_req_if.sink  req,
   lmcr_rsp_if.source rsp,
   lmcr_csr_if.sink  csr
);
   import lmcr_pkg::*;

   localparam int AW = $clog2(MAX_RADIUS + 1);
   localparam int EW = AW + 4;
   localparam int CW = COORD_BITS + 1;
   localparam int NW = $clog2(STEP_LIMIT + 1);

   cfg_type cfg_ff, cfg_in;

   logic                         active_ff;
   logic [AW-1:0]                a_ff, b_ff;
   logic signed [EW-1:0]         err_ff;
   logic [NW-1:0]                n_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [COLOR_W-1:0]           col_ff;

   logic                 pipe_ready, step_last, take;
   logic [AW-1:0]        r_sat, a_nx, b_nx;
   logic signed [EW-1:0] err_nx;
   logic signed [CW-1:0] px [8], py [8];
   logic signed [CW-1:0] sa, sb, scx, scy;
   logic [INDEX_W-1:0]   idx [8];

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_MATRIX_WIDTH:  cfg_in.width  = csr.data[SIDE_W-1:0];
            REG_MATRIX_HEIGHT: cfg_in.height = csr.data[SIDE_W-1:0];
            REG_HIDDEN_INDEX:  cfg_in.hidden = csr.data;
            REG_SWAP_AXES:     cfg_in.swap   = csr.data[0];
            REG_SERPENTINE:    cfg_in.serp   = csr.data[0];
            REG_MIRROR_WIDTH:  cfg_in.mirror = csr.data[0];
            REG_FLIP_HEIGHT:   cfg_in.flip   = csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: SIDE_W'(16), height: SIDE_W'(16), hidden: INDEX_W'(256),
            swap: 1'b0, serp: 1'b0, mirror: 1'b0, flip: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign r_sat = (int'(req.radius) > MAX_RADIUS) ? AW'(MAX_RADIUS) : AW'(req.radius);
   assign req.ready = !active_ff;
   assign take = req.valid && !active_ff;

   assign b_nx = AW'(b_ff + AW'(1));
   always_comb begin
      if (err_ff < 0) begin
         a_nx   = a_ff;
         err_nx = EW'(err_ff + $signed({2'b00, b_nx, 1'b1}));
      end else begin
         a_nx   = AW'(a_ff - AW'(1));
         err_nx = EW'(err_ff + $signed({1'b0, b_nx, 1'b0})
            - $signed({1'b0, a_nx, 1'b0}) + EW'(2));
      end
   end
   assign step_last = (a_ff == AW'(0)) || !($signed({1'b0, a_nx}) >= $signed({1'b0, b_nx}))
      || (n_ff == NW'(STEP_LIMIT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (take) begin
         active_ff <= 1'b1;
      end else if (active_ff && pipe_ready && step_last) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_ff   <= r_sat;
         b_ff   <= '0;
         err_ff <= EW'(1) - EW'(r_sat);
         n_ff   <= '0;
         cx_ff  <= req.center_x;
         cy_ff  <= req.center_y;
         col_ff <= req.color;
      end else if (active_ff && pipe_ready) begin
         a_ff   <= a_nx;
         b_ff   <= b_nx;
         err_ff <= err_nx;
         n_ff   <= NW'(n_ff + NW'(1));
      end
   end

   assign sa  = CW'(a_ff);
   assign sb  = CW'(b_ff);
   assign scx = CW'(cx_ff);
   assign scy = CW'(cy_ff);
   assign px[0] = scx + sa;  assign py[0] = scy + sb;
   assign px[1] = scx + sb;  assign py[1] = scy + sa;
   assign px[2] = scx - sa;  assign py[2] = scy + sb;
   assign px[3] = scx - sb;  assign py[3] = scy + sa;
   assign px[4] = scx - sa;  assign py[4] = scy - sb;
   assign px[5] = scx - sb;  assign py[5] = scy - sa;
   assign px[6] = scx + sa;  assign py[6] = scy - sb;
   assign px[7] = scx + sb;  assign py[7] = scy - sa;

   lmcr_map_pipe #(
      .COORD_BITS (COORD_BITS),
      .MAX_SIDE   (MAX_SIDE)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (active_ff),
      .in_ready  (pipe_ready),
      .in_px     (px),
      .in_py     (py),
      .in_color  (col_ff),
      .in_last   (step_last),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_idx   (idx),
      .out_color (rsp.pixel_color),
      .out_last  (rsp.last_step)
   );

   assign rsp.pixel_index_0 = idx[0];
   assign rsp.pixel_index_1 = idx[1];
   assign rsp.pixel_index_2 = idx[2];
   assign rsp.pixel_index_3 = idx[3];
   assign rsp.pixel_index_4 = idx[4];
   assign rsp.pixel_index_5 = idx[5];
   assign rsp.pixel_index_6 = idx[6];
   assign rsp.pixel_index_7 = idx[7];

endmodule

>>> verif/lmcr_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcr testbench interfaces
// Note: the channel interfaces are defined with the block in lmcr_if.sv;
// this file only holds the small record type that the checker keeps.
// ----------------------------------------------------------------------------
package lmcr_tb_pkg;
   import lmcr_pkg::*;

   typedef struct {
      logic [INDEX_W-1:0] idx [NUM_PTS];
      logic [COLOR_W-1:0] color;
      logic               last;
   } step_rec_type;

endpackage

>>> verif/lmcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcr_checker
// Watches the request, result and register channels, predicts the octant
// indices of every midpoint step and compares each result item in order.
// ----------------------------------------------------------------------------
module lmcr_checker
   import lmcr_pkg::*;
   import lmcr_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lmcr_req_if.sink   req_mon,
   lmcr_rsp_if.sink   rsp_mon,
   lmcr_csr_if.sink   csr_mon,
   input  logic       rsp_ready_in,
   input  logic       req_ready_in,
   input  logic       csr_ready_in,
   output int         error_count,
   output int         steps_pending
);

   logic [SIDE_W-1:0]  cur_width;
   logic [SIDE_W-1:0]  cur_height;
   logic [INDEX_W-1:0] cur_hidden;
   logic               cur_swap, cur_serp, cur_mirror, cur_flip;
   step_rec_type       expected_steps [$];

   assign steps_pending = expected_steps.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [INDEX_W-1:0] strip_index(input int px, input int py);
      int w, h, len, t, v;
      w = (cur_width > 64) ? 64 : cur_width;
      h = (cur_height > 64) ? 64 : cur_height;
      if (px < 0 || py < 0 || px >= w || py >= h) return cur_hidden;
      if (cur_mirror) px = w - 1 - px;
      if (cur_flip) py = h - 1 - py;
      if (cur_swap) begin
         t = px; px = py; py = t; len = w;
      end else begin
         len = h;
      end
      if (cur_serp && px[0]) v = px * len + (len - 1 - py);
      else v = px * len + py;
      return v[INDEX_W-1:0];
   endfunction

   task automatic predict_circle(input int cx, input int cy, input int rad,
                                 input logic [COLOR_W-1:0] col);
      int a, b, err, n;
      step_rec_type s;
      a = rad;
      b = 0;
      err = 1 - a;
      n = 0;
      do begin
         s.idx[0] = strip_index(cx + a, cy + b);
         s.idx[1] = strip_index(cx + b, cy + a);
         s.idx[2] = strip_index(cx - a, cy + b);
         s.idx[3] = strip_index(cx - b, cy + a);
         s.idx[4] = strip_index(cx - a, cy - b);
         s.idx[5] = strip_index(cx - b, cy - a);
         s.idx[6] = strip_index(cx + a, cy - b);
         s.idx[7] = strip_index(cx + b, cy - a);
         s.color = col;
         s.last = 1'b0;
         n++;
         b++;
         if (err < 0) err += 2 * b + 1;
         else begin
            a--;
            err += 2 * (b - a + 1);
         end
         s.last = (rad == 0) || !(a >= b && n < STEP_LIMIT);
         expected_steps.push_back(s);
      end while (!s.last);
   endtask

   always @(posedge clock) begin
      step_rec_type want;
      logic [INDEX_W-1:0] got [NUM_PTS];
      if (reset) begin
         cur_width <= 7'd16;
         cur_height <= 7'd16;
         cur_hidden <= 13'd256;
         cur_swap <= 1'b0;
         cur_serp <= 1'b0;
         cur_mirror <= 1'b0;
         cur_flip <= 1'b1;
         error_count = 0;
         expected_steps.delete();
      end else begin
         if (csr_mon.valid && csr_ready_in) begin
            case (csr_reg_type'(csr_mon.index))
               REG_MATRIX_WIDTH: cur_width <= csr_mon.data[SIDE_W-1:0];
               REG_MATRIX_HEIGHT: cur_height <= csr_mon.data[SIDE_W-1:0];
               REG_HIDDEN_INDEX: cur_hidden <= csr_mon.data;
               REG_SWAP_AXES: cur_swap <= csr_mon.data[0];
               REG_SERPENTINE: cur_serp <= csr_mon.data[0];
               REG_MIRROR_WIDTH: cur_mirror <= csr_mon.data[0];
               REG_FLIP_HEIGHT: cur_flip <= csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_ready_in)
            predict_circle(req_mon.center_x, req_mon.center_y,
               (req_mon.radius > 63) ? 63 : req_mon.radius, req_mon.color);
         if (rsp_mon.valid && rsp_ready_in) begin
            got = '{rsp_mon.pixel_index_0, rsp_mon.pixel_index_1,
               rsp_mon.pixel_index_2, rsp_mon.pixel_index_3, rsp_mon.pixel_index_4,
               rsp_mon.pixel_index_5, rsp_mon.pixel_index_6, rsp_mon.pixel_index_7};
            if (expected_steps.size() == 0) begin
               $display("%0t: result item with none expected", $realtime);
               error_count++;
            end else begin
               want = expected_steps.pop_front();
               for (int i = 0; i < NUM_PTS; i++)
                  if (got[i] !== want.idx[i])
                     report_mismatch($sformatf("pixel_index_%0d", i), got[i], want.idx[i]);
               if (rsp_mon.pixel_color !== want.color)
                  report_mismatch("pixel_color", rsp_mon.pixel_color, want.color);
               if (rsp_mon.last_step !== want.last)
                  report_mismatch("last_step", rsp_mon.last_step, want.last);
            end
         end
      end
   end

endmodule

>>> verif/led_matrix_circle_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_circle_rasterizer_tb
// Drives circle requests and register settings with random idling on both
// channels; the checker predicts every step and counts mismatches.
// ----------------------------------------------------------------------------
module led_matrix_circle_rasterizer_tb;
   import lmcr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   steps_pending;
   int   cycle_count = 0;
   int   send_idle_pct = 22;
   int   recv_idle_pct = 67;

   lmcr_req_if req ();
   lmcr_rsp_if rsp ();
   lmcr_csr_if csr ();

   always #1 clock = ~clock;

   led_matrix_circle_rasterizer i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   lmcr_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req.sink), .rsp_mon(rsp.sink),
      .csr_mon(csr.sink), .rsp_ready_in(rsp.ready), .req_ready_in(req.ready),
      .csr_ready_in(csr.ready), .error_count(error_count),
      .steps_pending(steps_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("led_matrix_circle_rasterizer_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(input csr_reg_type idx, input logic [12:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_circle(input logic [9:0] cx, input logic [9:0] cy,
                              input logic [5:0] rad, input logic [23:0] col);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req.valid <= 1'b1;
      req.center_x <= cx;
      req.center_y <= cy;
      req.radius <= rad;
      req.color <= col;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (steps_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input int w, input int h, input int hid, input bit sw,
                            input bit sp, input bit mi, input bit fl);
      drain();
      write_reg(REG_MATRIX_WIDTH, 13'(w));
      write_reg(REG_MATRIX_HEIGHT, 13'(h));
      write_reg(REG_HIDDEN_INDEX, 13'(hid));
      write_reg(REG_SWAP_AXES, 13'(sw));
      write_reg(REG_SERPENTINE, 13'(sp));
      write_reg(REG_MIRROR_WIDTH, 13'(mi));
      write_reg(REG_FLIP_HEIGHT, 13'(fl));
   endtask

   task automatic random_circle(input int side);
      int c;
      c = $urandom_range(99);
      if (c < 80)
         send_circle(10'($urandom_range(side + 8) - 4), 10'($urandom_range(side + 8) - 4),
            6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(12)),
            24'($urandom));
      else
         send_circle(10'($urandom), 10'($urandom), 6'($urandom), 24'($urandom));
   endtask

   initial begin
      req.valid = 1'b0;
      req.center_x = '0;
      req.center_y = '0;
      req.radius = '0;
      req.color = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed extremes of the fields, first at the reset setting, then at others.
      send_circle(10'd5, 10'd5, 6'd0, 24'h000000);
      send_circle(10'd8, 10'd8, 6'd3, 24'hFFFFFF);
      send_circle(10'h1FF, 10'h200, 6'd63, 24'hA5A5A5);
      send_circle(10'h200, 10'h1FF, 6'd1, 24'h5A5A5A);
      send_circle(10'h3FF, 10'h3FF, 6'd2, 24'h123456);
      send_circle(10'd32, 10'd32, 6'd63, 24'h654321);
      configure(1, 1, 0, 0, 0, 0, 0);
      send_circle(10'd0, 10'd0, 6'd0, 24'h00FF00);
      send_circle(10'd0, 10'd0, 6'd1, 24'h0000FF);
      configure(127, 127, 8191, 1, 1, 1, 1);
      send_circle(10'd63, 10'd0, 6'd63, 24'hFF0000);
      send_circle(10'd20, 10'd40, 6'd7, 24'h800001);
      configure(0, 5, 4096, 0, 1, 0, 0);
      send_circle(10'd0, 10'd2, 6'd2, 24'h111111);
      configure(64, 64, 4096, 1, 0, 1, 0);
      send_circle(10'd31, 10'd31, 6'd40, 24'h222222);
      send_circle(10'd0, 10'd63, 6'd5, 24'h333333);

      for (int ph = 0; ph < 6; ph++) begin
         int w, h;
         w = (ph == 0) ? 64 : (ph == 1) ? 1 : $urandom_range(2, 64);
         h = (ph == 2) ? 64 : (ph == 3) ? 1 : $urandom_range(2, 64);
         if (ph == 2) begin
            send_idle_pct = 67;
            recv_idle_pct = 22;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(w, h, $urandom_range(8191), 1'($urandom), 1'($urandom),
            1'($urandom), 1'($urandom));
         for (int k = 0; k < 50; k++) begin
            if (ph == 5 && k == 25) drain();
            random_circle((w > h) ? w : h);
         end
      end

      while (steps_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("led_matrix_circle_rasterizer_tb: done, clean");
      else
         $display("led_matrix_circle_rasterizer_tb: done, errors");
      $finish;
   end

endmodule
